// ----- hdl/ppr_pkg.sv -----
package ppr_pkg;

    localparam int T_FRAC_BITS_DEF = 12;

    // field and port widths
    localparam int TAP_W      = 16;
    localparam int WEIGHT_W   = 18;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TYPE_W     = 3;
    localparam int KW_W       = 15;
    localparam int COEF_IN_W  = 16;

    // datapath widths
    localparam int U_W       = 16;
    localparam int COEF_W    = 26;
    localparam int ACC_FRAC  = 24;
    localparam int Q24_SHIFT = 10;
    localparam int KQ_W      = COEF_W + Q24_SHIFT;

    localparam int ONE_Q14 = 16384;

    // final scaling: Q24 / 12 -> Q14 is a shift by 12 and a divide by 3
    localparam int FIN_SHIFT  = 12;
    localparam int SAT_SPAN   = 393216;
    localparam int FIN_OFFSET = 6144 + SAT_SPAN * 4096;
    localparam int XP_LIMIT   = 2 * SAT_SPAN;
    localparam int Y_W        = 20;
    localparam int DIV3_MUL   = 699051;
    localparam int DIV3_SHIFT = 21;
    localparam int WEIGHT_BIAS = 131072;
    localparam int WEIGHT_MAX  = 131071;
    localparam int WEIGHT_MIN  = -131072;

    typedef enum logic [TYPE_W-1:0] {
        KT_BOX      = 3'd0,
        KT_BILINEAR = 3'd1,
        KT_BELL     = 3'd2,
        KT_BSPLINE  = 3'd3,
        KT_MITCHELL = 3'd4,
        KT_QUAD     = 3'd5
    } kernel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TYPE  = 3'd0,
        REG_KERNEL_WIDTH = 3'd1,
        REG_COEF_B       = 3'd2,
        REG_COEF_C       = 3'd3,
        REG_COEF_R       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        kernel_t               kernel_type;
        logic [KW_W-1:0]       kernel_width;
        logic [COEF_IN_W-1:0]  coef_b;
        logic [COEF_IN_W-1:0]  coef_c;
        logic [COEF_IN_W-1:0]  coef_r;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kernel_type:  KT_MITCHELL,
        kernel_width: 15'd8192,
        coef_b:       16'd5461,
        coef_c:       16'd5461,
        coef_r:       16'd16384
    };

    // bypass: weight is a constant, one selects 1.0 over 0.0
    typedef struct packed {
        logic bypass;
        logic one;
    } flags_t;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [KQ_W-1:0]     kq_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

endpackage

// ----- hdl/ppr_select.sv -----
module ppr_select
    import ppr_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [TAP_W-1:0] tap_offset,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [U_W-1:0]          u_o,
    output kq_t                     k3_o,
    output kq_t                     k2_o,
    output kq_t                     k1_o,
    output kq_t                     k0_o,
    output flags_t                  flags_o
);

    localparam int CMP_W = U_W + 2;

    function automatic kq_t to_q24(coef_t k);
        return kq_t'(k) <<< Q24_SHIFT;
    endfunction

    logic           ready_a, ready_b, ready_c;

    // stage A: magnitude of the offset
    logic           va_reg;
    logic [U_W-1:0] a_reg, a_next;

    // stage B: segment choice and polynomial argument
    logic           vb_reg;
    logic [U_W-1:0] ub_reg, ub_next;
    logic           segb_reg, segb_next;
    flags_t         flagsb_reg, flagsb_next;

    // stage C: coefficient set
    logic           vc_reg;
    logic [U_W-1:0] uc_reg;
    kq_t            k3_reg, k2_reg, k1_reg, k0_reg;
    kq_t            k3_next, k2_next, k1_next, k0_next;
    flags_t         flagsc_reg;

    logic [CMP_W-1:0] a_x, a2_x, a3_x, w_x;
    logic             a_le_w, a_ge_w, a2_lt_w, a3_lt_w, a3_le_w;
    logic [U_W-1:0]   u_far;

    coef_t bs, cs, rs, k3c, k2c, k1c;
    kq_t   wq;

    assign ready_c  = !vc_reg || out_ready;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    assign a_next = tap_offset[TAP_W-1] ? U_W'(-tap_offset) : U_W'(tap_offset);

    assign a_x     = CMP_W'(a_reg);
    assign a2_x    = a_x << 1;
    assign a3_x    = a_x + a2_x;
    assign w_x     = CMP_W'(cfg.kernel_width);
    assign a_le_w  = a_x <= w_x;
    assign a_ge_w  = a_x >= w_x;
    assign a2_lt_w = a2_x < w_x;
    assign a3_lt_w = a3_x < w_x;
    assign a3_le_w = a3_x <= w_x;
    assign u_far   = U_W'(w_x - a_x);

    always_comb begin
        flagsb_next = '{bypass: 1'b0, one: 1'b0};
        segb_next   = 1'b0;
        ub_next     = a_reg;
        unique case (cfg.kernel_type)
            KT_BOX: begin
                flagsb_next.bypass = 1'b1;
                flagsb_next.one    = a_le_w;
            end
            KT_BILINEAR: begin
                ub_next = u_far;
            end
            KT_BELL: begin
                segb_next = !a3_lt_w;
                ub_next   = segb_next ? u_far : a_reg;
            end
            KT_BSPLINE: begin
                segb_next = !a2_lt_w;
                ub_next   = segb_next ? u_far : a_reg;
            end
            KT_MITCHELL: begin
                segb_next = !a2_lt_w;
            end
            KT_QUAD: begin
                segb_next = !a3_le_w;
            end
            default: begin
                flagsb_next.bypass = 1'b1;
            end
        endcase
        // zero at or beyond the half-width
        if (cfg.kernel_type != KT_BOX && a_ge_w) begin
            flagsb_next = '{bypass: 1'b1, one: 1'b0};
        end
    end

    assign bs = coef_t'(cfg.coef_b);
    assign cs = coef_t'(cfg.coef_c);
    assign rs = coef_t'(cfg.coef_r);
    assign wq = kq_t'(cfg.kernel_width) <<< (ACC_FRAC - T_FRAC_BITS);

    // coefficients of twelve times the kernel: k3..k1 built in Q14 and shifted to Q24, k0 in Q24
    always_comb begin
        k3c     = '0;
        k2c     = '0;
        k1c     = '0;
        k0_next = '0;
        unique case (cfg.kernel_type)
            KT_BILINEAR: begin
                k1c = coef_t'(12 * ONE_Q14);
            end
            KT_BELL: begin
                if (!segb_reg) begin
                    k2c     = coef_t'(-12 * ONE_Q14);
                    k0_next = kq_t'(6) * wq;
                end else begin
                    k2c = coef_t'(6 * ONE_Q14);
                end
            end
            KT_BSPLINE: begin
                if (!segb_reg) begin
                    k3c     = coef_t'(6 * ONE_Q14);
                    k2c     = coef_t'(-12 * ONE_Q14);
                    k0_next = wq <<< 2;
                end else begin
                    k3c = coef_t'(2 * ONE_Q14);
                end
            end
            KT_MITCHELL: begin
                if (!segb_reg) begin
                    k3c     = coef_t'(24 * ONE_Q14) - coef_t'(18) * bs - coef_t'(12) * cs;
                    k2c     = coef_t'(-36 * ONE_Q14) + coef_t'(24) * bs + coef_t'(12) * cs;
                    k0_next = to_q24(coef_t'(12 * ONE_Q14) - coef_t'(4) * bs);
                end else begin
                    k3c     = -(coef_t'(2) * bs) - coef_t'(12) * cs;
                    k2c     = coef_t'(12) * bs + coef_t'(60) * cs;
                    k1c     = -(coef_t'(24) * bs) - coef_t'(96) * cs;
                    k0_next = to_q24(coef_t'(16) * bs + coef_t'(48) * cs);
                end
            end
            KT_QUAD: begin
                if (!segb_reg) begin
                    k2c     = -(coef_t'(24) * rs);
                    k0_next = to_q24(coef_t'(6) * rs + coef_t'(6 * ONE_Q14));
                end else begin
                    k2c     = coef_t'(12) * rs;
                    k1c     = -(coef_t'(24) * rs) - coef_t'(6 * ONE_Q14);
                    k0_next = to_q24(coef_t'(9) * rs + coef_t'(9 * ONE_Q14));
                end
            end
            default: begin
                k3c = '0;
            end
        endcase
        k3_next = to_q24(k3c);
        k2_next = to_q24(k2c);
        k1_next = to_q24(k1c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                va_reg <= in_valid;
            end
            if (ready_b) begin
                vb_reg <= va_reg;
            end
            if (ready_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a) begin
            a_reg <= a_next;
        end
        if (ready_b) begin
            ub_reg     <= ub_next;
            segb_reg   <= segb_next;
            flagsb_reg <= flagsb_next;
        end
        if (ready_c) begin
            uc_reg     <= ub_reg;
            flagsc_reg <= flagsb_reg;
            k3_reg     <= k3_next;
            k2_reg     <= k2_next;
            k1_reg     <= k1_next;
            k0_reg     <= k0_next;
        end
    end

    assign out_valid = vc_reg;
    assign u_o       = uc_reg;
    assign k3_o      = k3_reg;
    assign k2_o      = k2_reg;
    assign k1_o      = k1_reg;
    assign k0_o      = k0_reg;
    assign flags_o   = flagsc_reg;

endmodule

// ----- hdl/ppr_hstep.sv -----
module ppr_hstep
    import ppr_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    parameter int ACC_W       = 49,
    parameter int CARRY_W     = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ACC_W-1:0] acc_i,
    input  logic [U_W-1:0]          u_i,
    input  kq_t                     kadd_i,
    input  logic [CARRY_W-1:0]      carry_i,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] acc_o,
    output logic [U_W-1:0]          u_o,
    output logic [CARRY_W-1:0]      carry_o
);

    localparam int LO_W = ACC_W / 2;
    localparam int HI_W = ACC_W - LO_W;
    localparam int P_W  = ACC_W + U_W + 1;
    localparam logic [P_W-1:0] HALF = P_W'(1) << (T_FRAC_BITS - 1);

    logic ready_m, ready_s;

    // stage M: partial products of acc * u
    logic                      vm_reg;
    logic [LO_W+U_W-1:0]       lo_reg, lo_next;
    logic signed [HI_W+U_W:0]  hi_reg, hi_next;
    kq_t                       kadd_reg;
    logic [U_W-1:0]            um_reg;
    logic [CARRY_W-1:0]        carrym_reg;

    // stage S: recombine, round, add the next coefficient
    logic                      vs_reg;
    logic signed [P_W-1:0]     sum;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [U_W-1:0]            us_reg;
    logic [CARRY_W-1:0]        carrys_reg;

    assign ready_s  = !vs_reg || out_ready;
    assign ready_m  = !vm_reg || ready_s;
    assign in_ready = ready_m;

    assign lo_next = acc_i[LO_W-1:0] * u_i;
    assign hi_next = $signed(acc_i[ACC_W-1:LO_W]) * $signed({1'b0, u_i});

    // floor((acc*u + half) / 2^T) + k == floor((acc*u + half + k*2^T) / 2^T)
    assign sum = (P_W'(hi_reg) <<< LO_W) + P_W'(lo_reg)
               + (P_W'(kadd_reg) <<< T_FRAC_BITS) + HALF;
    assign acc_next = ACC_W'(sum >>> T_FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
            vs_reg <= 1'b0;
        end else begin
            if (ready_m) begin
                vm_reg <= in_valid;
            end
            if (ready_s) begin
                vs_reg <= vm_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_m) begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            kadd_reg   <= kadd_i;
            um_reg     <= u_i;
            carrym_reg <= carry_i;
        end
        if (ready_s) begin
            acc_reg    <= acc_next;
            us_reg     <= um_reg;
            carrys_reg <= carrym_reg;
        end
    end

    assign out_valid = vs_reg;
    assign acc_o     = acc_reg;
    assign u_o       = us_reg;
    assign carry_o   = carrys_reg;

endmodule

// ----- hdl/ppr_fin.sv -----
module ppr_fin
    import ppr_pkg::*;
#(
    parameter int ACC_W = 49
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ACC_W-1:0] acc_i,
    input  flags_t                  flags_i,
    output logic                    out_valid,
    input  logic                    out_ready,
    output weight_t                 weight_o
);

    localparam int Z_W  = ACC_W + 1;
    localparam int XP_W = Z_W - FIN_SHIFT;

    logic ready_1, ready_2, ready_3;

    // stage 1: round, scale by 1/4096, offset into the unsigned divide range
    logic                   v1_reg;
    logic signed [Z_W-1:0]  z;
    logic signed [XP_W-1:0] xp;
    logic [Y_W-1:0]         y_reg;
    logic                   hs1_reg, ls1_reg;
    flags_t                 flags1_reg;

    // stage 2: divide by three through the reciprocal
    logic                   v2_reg;
    logic [2*Y_W-1:0]       prod;
    logic [WEIGHT_W-1:0]    q_reg;
    logic                   hs2_reg, ls2_reg;
    flags_t                 flags2_reg;

    // stage 3: bypass and saturation select, output register
    logic                   vo_reg;
    weight_t                weight_reg, weight_next;

    assign ready_3  = !vo_reg || out_ready;
    assign ready_2  = !v2_reg || ready_3;
    assign ready_1  = !v1_reg || ready_2;
    assign in_ready = ready_1;

    assign z    = Z_W'(acc_i) + Z_W'(FIN_OFFSET);
    assign xp   = XP_W'(z >>> FIN_SHIFT);
    assign prod = y_reg * Y_W'(DIV3_MUL);

    always_comb begin
        priority if (flags2_reg.bypass) begin
            weight_next = flags2_reg.one ? weight_t'(ONE_Q14) : '0;
        end else if (hs2_reg) begin
            weight_next = weight_t'(WEIGHT_MAX);
        end else if (ls2_reg) begin
            weight_next = weight_t'(WEIGHT_MIN);
        end else begin
            weight_next = weight_t'(q_reg - WEIGHT_W'(WEIGHT_BIAS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ready_1) begin
                v1_reg <= in_valid;
            end
            if (ready_2) begin
                v2_reg <= v1_reg;
            end
            if (ready_3) begin
                vo_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_1) begin
            y_reg      <= xp[Y_W-1:0];
            hs1_reg    <= xp >= XP_W'(XP_LIMIT);
            ls1_reg    <= xp[XP_W-1];
            flags1_reg <= flags_i;
        end
        if (ready_2) begin
            q_reg      <= prod[DIV3_SHIFT +: WEIGHT_W];
            hs2_reg    <= hs1_reg;
            ls2_reg    <= ls1_reg;
            flags2_reg <= flags1_reg;
        end
        if (ready_3) begin
            weight_reg <= weight_next;
        end
    end

    assign out_valid = vo_reg;
    assign weight_o  = weight_reg;

endmodule

// ----- hdl/piecewise_poly_resample_kernel.sv -----
// Piecewise polynomial resampling kernel.
// Input stream s_*: one signed tap offset t (Q3.12 at the default T_FRAC_BITS)
// per transaction. Output stream m_*: the kernel weight for that offset,
// signed Q3.14, saturated, one result per input, in input order.
// Configuration channel cfg_*: cfg_index selects kernel_type (0), kernel_width
// (1), coef_b (2), coef_c (3) or coef_r (4); other indexes are ignored.
// cfg_ready is always high. Write it only while no transaction is in flight.
// A new offset can be taken every cycle while s_tready is high. The pipeline
// has three stages of argument and coefficient selection, three Horner steps
// of two stages each (split multiply, then recombine and round), and three
// stages of scaling, divide by three and saturation.
// Reset (aresetn low, synchronous) empties the pipeline and returns the
// registers to a Mitchell kernel with B = C = 1/3 and half-width 2.0.
// When m_tready is low each stage holds once the stage after it is full;
// empty stages keep filling, so s_tready drops only when all 12 stages hold data.
module piecewise_poly_resample_kernel
    import ppr_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] tap_offset
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [17:0] weight, [23:18] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int GROW       = (T_FRAC_BITS < 15) ? (15 - T_FRAC_BITS) : 0;
    localparam int ACC_W      = 40 + 3 * GROW;
    localparam int PIPE_DEPTH = 12;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
    localparam int C1_W       = 2 * KQ_W + $bits(flags_t);
    localparam int C2_W       = KQ_W + $bits(flags_t);
    localparam int C3_W       = $bits(flags_t);

    cfg_t cfg_reg, cfg_next;

    // selection stage outputs
    logic           sel_valid, sel_ready;
    logic [U_W-1:0] sel_u;
    kq_t            sel_k3, sel_k2, sel_k1, sel_k0;
    flags_t         sel_flags;

    // Horner steps
    logic signed [ACC_W-1:0] acc0, acc1, acc2, acc3;
    logic                    h1_valid, h1_ready, h2_valid, h2_ready, h3_valid, h3_ready;
    logic [U_W-1:0]          h1_u, h2_u;
    logic [C1_W-1:0]         c1_in, c1_out;
    logic [C2_W-1:0]         c2_in, c2_out;
    logic [C3_W-1:0]         c3_in, c3_out;
    kq_t                     h1_k1, h1_k0, h2_k0;
    flags_t                  h1_flags, h2_flags, h3_flags;

    weight_t                 weight;

    logic                    in_xfer, out_xfer;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KERNEL_TYPE:  cfg_next.kernel_type  = kernel_t'(cfg_data[TYPE_W-1:0]);
                REG_KERNEL_WIDTH: cfg_next.kernel_width = cfg_data[KW_W-1:0];
                REG_COEF_B:       cfg_next.coef_b       = cfg_data[COEF_IN_W-1:0];
                REG_COEF_C:       cfg_next.coef_c       = cfg_data[COEF_IN_W-1:0];
                REG_COEF_R:       cfg_next.coef_r       = cfg_data[COEF_IN_W-1:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ppr_select #(
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .tap_offset($signed(s_tdata[TAP_W-1:0])),
        .cfg       (cfg_reg),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .u_o       (sel_u),
        .k3_o      (sel_k3),
        .k2_o      (sel_k2),
        .k1_o      (sel_k1),
        .k0_o      (sel_k0),
        .flags_o   (sel_flags)
    );

    assign acc0  = ACC_W'(sel_k3);
    assign c1_in = {sel_k1, sel_k0, sel_flags};

    ppr_hstep #(
        .T_FRAC_BITS(T_FRAC_BITS),
        .ACC_W      (ACC_W),
        .CARRY_W    (C1_W)
    ) u_hstep1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (sel_valid),
        .in_ready (sel_ready),
        .acc_i    (acc0),
        .u_i      (sel_u),
        .kadd_i   (sel_k2),
        .carry_i  (c1_in),
        .out_valid(h1_valid),
        .out_ready(h1_ready),
        .acc_o    (acc1),
        .u_o      (h1_u),
        .carry_o  (c1_out)
    );

    assign {h1_k1, h1_k0, h1_flags} = c1_out;
    assign c2_in = {h1_k0, h1_flags};

    ppr_hstep #(
        .T_FRAC_BITS(T_FRAC_BITS),
        .ACC_W      (ACC_W),
        .CARRY_W    (C2_W)
    ) u_hstep2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (h1_valid),
        .in_ready (h1_ready),
        .acc_i    (acc1),
        .u_i      (h1_u),
        .kadd_i   (h1_k1),
        .carry_i  (c2_in),
        .out_valid(h2_valid),
        .out_ready(h2_ready),
        .acc_o    (acc2),
        .u_o      (h2_u),
        .carry_o  (c2_out)
    );

    assign {h2_k0, h2_flags} = c2_out;
    assign c3_in = h2_flags;

    ppr_hstep #(
        .T_FRAC_BITS(T_FRAC_BITS),
        .ACC_W      (ACC_W),
        .CARRY_W    (C3_W)
    ) u_hstep3 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (h2_valid),
        .in_ready (h2_ready),
        .acc_i    (acc2),
        .u_i      (h2_u),
        .kadd_i   (h2_k0),
        .carry_i  (c3_in),
        .out_valid(h3_valid),
        .out_ready(h3_ready),
        .acc_o    (acc3),
        .u_o      (),
        .carry_o  (c3_out)
    );

    assign h3_flags = c3_out;

    ppr_fin #(
        .ACC_W(ACC_W)
    ) u_fin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (h3_valid),
        .in_ready (h3_ready),
        .acc_i    (acc3),
        .flags_i  (h3_flags),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .weight_o (weight)
    );

    assign m_tdata = {{(M_TDATA_W - WEIGHT_W){1'b0}}, weight};

    // transactions in flight
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_xfer && !out_xfer) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!in_xfer && out_xfer) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output is not stalled");

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt_reg != '0))
        else $error("output valid with no transaction in flight");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == CNT_W'(PIPE_DEPTH) && !m_tready) |-> !s_tready)
        else $error("input accepted with a full, stalled pipeline");

endmodule
